@@ rtl/frak_pkg.sv @@
// Package for the frame receive and acknowledgement engine.
// Holds the front-to-back command type, status codes and frame constants.
// Depends on nothing.
`default_nettype none
package frak_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h7e;
	localparam logic [7:0] CMD_START = 8'h00;
	localparam logic [7:0] CMD_DATA  = 8'h01;
	localparam logic [7:0] CMD_END   = 8'h81;

	localparam logic [2:0] ST_ACK       = 3'd0;
	localparam logic [2:0] ST_READ      = 3'd1;
	localparam logic [2:0] ST_BAD_FLAG  = 3'd2;
	localparam logic [2:0] ST_BAD_SUM   = 3'd3;
	localparam logic [2:0] ST_BAD_CMD   = 3'd4;
	localparam logic [2:0] ST_TRUNC     = 3'd5;

	typedef enum logic [2:0] {
		JOB_READ,    // read one store byte
		JOB_STATUS,  // one status result
		JOB_PAYLOAD, // one payload byte into the staging buffer
		JOB_FRAME,   // good sum: act on command and acknowledge
		JOB_NONE     // byte consumed with no result and no work
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [2:0]  status;
		logic [7:0]  data;      // payload byte or sum low
		logic [15:0] addr;      // read address / payload index
		logic [7:0]  src;
		logic [7:0]  dst;
		logic [7:0]  cmd;
		logic [7:0]  seq;
		logic [5:0]  plen;
	} job_t;

endpackage
`default_nettype wire

@@ rtl/frak_front.sv @@
// Front part: parses received bytes and turns each input item that needs work into a job.
// Depends on frak_pkg.
`default_nettype none
module frak_front #(
	parameter int MAX_PAYLOAD = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             op,
	input  wire logic [7:0]       rx_byte,
	input  wire logic             frame_start,
	input  wire logic [9:0]       read_addr,
	output logic                  job_valid,
	input  wire logic             job_stall,
	output frak_pkg::job_t        job
);
	import frak_pkg::*;

	logic [5:0]  pos_q;        // 0 idle, else index of next byte (saturates in payload)
	logic [5:0]  k_q;          // payload index
	logic        in_pay_q;
	logic        flag_ok_q;
	logic [15:0] sum_q;
	logic [7:0]  src_q, dst_q, cmd_q, seq_q, sumh_q;
	logic [5:0]  plen_q;
	logic        sumh_phase_q; // next byte is sum low
	logic        hold_valid_q;
	job_t        hold_q;

	job_t        nj;
	logic        take;

	assign in_stall  = hold_valid_q && job_stall;
	assign take      = in_valid && !in_stall;
	assign job_valid = hold_valid_q;
	assign job       = hold_q;

	always_comb begin
		nj        = hold_q;
		nj.kind   = JOB_NONE;
		nj.status = ST_ACK;
		nj.data   = rx_byte;
		nj.addr   = {6'd0, read_addr};
		nj.src    = src_q;
		nj.dst    = dst_q;
		nj.cmd    = cmd_q;
		nj.seq    = seq_q;
		nj.plen   = plen_q;
		if (op) begin
			nj.kind = JOB_READ;
		end else if (frame_start) begin
			if (pos_q != 6'd0) begin
				nj.kind   = JOB_STATUS;
				nj.status = ST_TRUNC;
			end
		end else if (pos_q == 6'd5) begin
			if (!flag_ok_q || rx_byte > 8'(MAX_PAYLOAD)) begin
				nj.kind   = JOB_STATUS;
				nj.status = ST_BAD_FLAG;
			end
		end else if (in_pay_q) begin
			nj.kind = JOB_PAYLOAD;
			nj.addr = {10'd0, k_q};
		end else if (sumh_phase_q) begin
			if ({sumh_q, rx_byte} != sum_q) begin
				nj.kind   = JOB_STATUS;
				nj.status = ST_BAD_SUM;
			end else if (cmd_q == CMD_START || cmd_q == CMD_DATA || cmd_q == CMD_END) begin
				nj.kind = JOB_FRAME;
			end else begin
				nj.kind   = JOB_STATUS;
				nj.status = ST_BAD_CMD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			k_q          <= '0;
			in_pay_q     <= 1'b0;
			flag_ok_q    <= 1'b0;
			sum_q        <= '0;
			src_q        <= '0;
			dst_q        <= '0;
			cmd_q        <= '0;
			seq_q        <= '0;
			plen_q       <= '0;
			sumh_q       <= '0;
			sumh_phase_q <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (take && nj.kind != JOB_NONE) begin
				hold_valid_q <= 1'b1;
				hold_q       <= nj;
			end else if (!job_stall) begin
				hold_valid_q <= 1'b0;
			end
			if (take) begin
				if (!op) begin
					if (frame_start) begin
						flag_ok_q    <= (rx_byte == FLAG_BYTE);
						sum_q        <= '0;
						pos_q        <= 6'd1;
						in_pay_q     <= 1'b0;
						sumh_phase_q <= 1'b0;
					end else if (pos_q != 6'd0) begin
						if (pos_q < 6'd6) begin
							sum_q <= sum_q + {8'd0, rx_byte};
							pos_q <= pos_q + 6'd1;
							case (pos_q)
								6'd1: src_q <= rx_byte;
								6'd2: dst_q <= rx_byte;
								6'd3: cmd_q <= rx_byte;
								6'd4: seq_q <= rx_byte;
								default: begin
									if (!flag_ok_q || rx_byte > 8'(MAX_PAYLOAD)) begin
										pos_q <= '0;
									end else begin
										plen_q   <= rx_byte[5:0];
										k_q      <= '0;
										in_pay_q <= (rx_byte != 8'd0);
									end
								end
							endcase
						end else if (in_pay_q) begin
							sum_q    <= sum_q + {8'd0, rx_byte};
							k_q      <= k_q + 6'd1;
							in_pay_q <= (k_q + 6'd1) != plen_q;
						end else if (!sumh_phase_q) begin
							sumh_q       <= rx_byte;
							sumh_phase_q <= 1'b1;
						end else begin
							pos_q        <= '0;
							sumh_phase_q <= 1'b0;
						end
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/frak_queue.sv @@
// Short job queue between the front and back parts.
// Depends on frak_pkg.
`default_nettype none
module frak_queue (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_valid,
	output logic           wr_stall,
	input  frak_pkg::job_t wr_job,
	output logic           rd_valid,
	input  wire logic      rd_stall,
	output frak_pkg::job_t rd_job
);
	import frak_pkg::*;

	job_t       mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       push, pop;

	assign wr_stall = (cnt_q == 3'd4);
	assign rd_valid = (cnt_q != 3'd0);
	assign rd_job   = mem_q[rp_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop)  rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop};
		end
	end

endmodule
`default_nettype wire

@@ rtl/frak_back.sv @@
// Back part: stages payload, commits to the file store, emits results.
// Depends on frak_pkg.
`default_nettype none
module frak_back #(
	parameter int STORE_DEPTH = 1024,
	parameter int MAX_PAYLOAD = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        job_valid,
	output logic             job_stall,
	input  frak_pkg::job_t   job,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic [2:0]       status,
	output logic             last,
	output logic             file_complete,
	output logic [15:0]      file_length,
	output logic [10:0]      bytes_stored
);
	import frak_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int PW = $clog2(MAX_PAYLOAD);
	localparam int SPW = AW + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_RDWAIT, S_COPY, S_ACK
	} state_t;

	state_t           state_q;
	logic [7:0]       pbuf_q [MAX_PAYLOAD];
	logic [7:0]       store_q [STORE_DEPTH];
	logic [7:0]       rd_data_q;
	logic             rd_oob_q;
	logic [7:0]       pb_rd_q;
	logic [PW:0]      cp_idx_q;
	logic [5:0]       plen_q;
	logic [7:0]       last_seq_q;
	logic [15:0]      ann_len_q;
	logic [SPW-1:0]   sptr_q;
	logic             complete_q;
	logic [3:0]       ack_i_q;
	logic [7:0]       ack_q [9];
	logic             ob_valid_q;
	logic             ob_set;
	logic             cp_we;
	logic [7:0]       hi_b, lo_b;
	logic [15:0]      ack_sum;
	logic             can_out;

	assign can_out   = !ob_valid_q || !out_stall;
	assign out_valid = ob_valid_q;
	assign job_stall = !(state_q == S_IDLE && can_out);
	assign cp_we     = (state_q == S_COPY) && (cp_idx_q != '0) &&
	                   (sptr_q < SPW'(STORE_DEPTH));
	assign ack_sum   = 16'(job.dst) + 16'(job.src) + 16'(job.cmd) + 16'(job.seq) + 16'd2;
	// a new result is loaded into the output register this cycle
	assign ob_set    = (state_q == S_IDLE && job_valid && can_out && job.kind == JOB_STATUS) ||
	                   (state_q == S_RDWAIT) || (state_q == S_ACK && can_out);

	always_comb begin
		hi_b = (job.plen > 6'd0) ? pbuf_q[0] : 8'd0;
		lo_b = (job.plen > 6'd1) ? pbuf_q[1] : 8'd0;
	end

	// Store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cp_we) store_q[sptr_q[AW-1:0]] <= pb_rd_q;
		rd_data_q <= store_q[job.addr[AW-1:0]];
		rd_oob_q  <= {6'd0, job.addr[9:0]} >= 16'(STORE_DEPTH);
		pb_rd_q   <= pbuf_q[cp_idx_q[PW-1:0]];
		if (job_valid && !job_stall && job.kind == JOB_PAYLOAD)
			pbuf_q[job.addr[PW-1:0]] <= job.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ob_valid_q <= 1'b0;
			last_seq_q <= 8'd255;
			ann_len_q  <= '0;
			sptr_q     <= '0;
			complete_q <= 1'b0;
			cp_idx_q   <= '0;
			ack_i_q    <= '0;
			plen_q     <= '0;
		end else begin
			ob_valid_q <= ob_set || (ob_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (job_valid && can_out) begin
						case (job.kind)
							JOB_READ: state_q <= S_RDWAIT;
							JOB_STATUS: begin
								out_byte      <= '0;
								status        <= job.status;
								last          <= 1'b1;
								file_complete <= complete_q;
								file_length   <= ann_len_q;
								bytes_stored  <= 11'(sptr_q);
							end
							JOB_FRAME: begin
								ack_q[0] <= FLAG_BYTE;
								ack_q[1] <= job.dst;
								ack_q[2] <= job.src;
								ack_q[3] <= job.cmd;
								ack_q[4] <= job.seq;
								ack_q[5] <= 8'd1;
								ack_q[6] <= 8'd1;
								ack_q[7] <= ack_sum[15:8];
								ack_q[8] <= ack_sum[7:0];
								ack_i_q  <= '0;
								state_q  <= S_ACK;
								if (job.cmd == CMD_START) begin
									ann_len_q  <= {hi_b, lo_b};
									last_seq_q <= job.seq;
									sptr_q     <= '0;
									complete_q <= 1'b0;
								end else if (job.cmd == CMD_DATA) begin
									last_seq_q <= job.seq;
									if (((job.seq - last_seq_q) & 8'd15) == 8'd1 &&
									    job.plen != 6'd0) begin
										plen_q   <= job.plen;
										cp_idx_q <= '0;
										state_q  <= S_COPY;
									end
								end else begin
									complete_q <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				S_RDWAIT: begin
					out_byte      <= rd_oob_q ? 8'd0 : rd_data_q;
					status        <= ST_READ;
					last          <= 1'b1;
					file_complete <= complete_q;
					file_length   <= ann_len_q;
					bytes_stored  <= 11'(sptr_q);
					state_q       <= S_IDLE;
				end
				S_COPY: begin
					// index 0 primes the buffer read; each write stores the byte that pb_rd_q registered for the previous index
					if (cp_we) sptr_q <= sptr_q + SPW'(1);
					if ({1'b0, cp_idx_q} == 7'(plen_q))
						state_q <= S_ACK;
					else
						cp_idx_q <= cp_idx_q + (PW+1)'(1);
				end
				S_ACK: begin
					if (can_out) begin
						out_byte      <= ack_q[ack_i_q];
						status        <= ST_ACK;
						last          <= (ack_i_q == 4'd8);
						file_complete <= complete_q;
						file_length   <= ann_len_q;
						bytes_stored  <= 11'(sptr_q);
						ack_i_q       <= ack_i_q + 4'd1;
						if (ack_i_q == 4'd8) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/frame_receive_ack_engine.sv @@
// Top level of the frame receive and acknowledgement engine.
// Depends on frak_pkg, frak_front, frak_queue and frak_back.
//
//   channel | handshake             | fields
//   input   | valid / stall         | op rx_byte frame_start read_addr
//   output  | out_valid / out_stall | out_byte status last file_complete file_length bytes_stored
//
// The front parser registers each job that it makes; results are made by the back.
// A read passes through the registered store port (S_IDLE, then S_RDWAIT); an ack is nine output bytes.
// A good append copies its payload at one byte per cycle over the store write port,
// after priming the buffer read; frame end is handled as accept, copy, then nine ack
// bytes, and the four-entry queue absorbs this work.
// Reset clears control state only; the store is undefined until written.
// Either side may stall at any time; held results never change while stalled.
`default_nettype none
module frame_receive_ack_engine #(
	parameter int STORE_DEPTH = 1024,
	parameter int MAX_PAYLOAD = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	output logic             stall,
	input  wire logic        op,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        frame_start,
	input  wire logic [9:0]  read_addr,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic [2:0]       status,
	output logic             last,
	output logic             file_complete,
	output logic [15:0]      file_length,
	output logic [10:0]      bytes_stored
);
	import frak_pkg::*;

	job_t f_job, b_job;
	logic f_valid, f_stall, b_valid, b_stall;

	// Parse and classify each item
	frak_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk, .arst_n, .in_valid(valid), .in_stall(stall), .op, .rx_byte,
		.frame_start, .read_addr, .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
	);

	// Decouple parser from the slower commit and acknowledge work
	frak_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_job(f_job),
		.rd_valid(b_valid), .rd_stall(b_stall), .rd_job(b_job)
	);

	// Execute jobs and drive results
	frak_back #(.STORE_DEPTH(STORE_DEPTH), .MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
		.clk, .arst_n, .job_valid(b_valid), .job_stall(b_stall), .job(b_job),
		.out_valid, .out_stall, .out_byte, .status, .last, .file_complete,
		.file_length, .bytes_stored
	);

endmodule
`default_nettype wire

@@ rtl/frak_checker.sv @@
// Port checker for the frame receive and acknowledgement engine.
// Depends on the top level's ports only; bound below.
`default_nettype none
module frak_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  out_byte,
	input wire logic [2:0]  status,
	input wire logic        last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte))
		else $error("stalled result changed");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 3'd0 |-> last)
		else $error("single result without last");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status >= 3'd2 |-> out_byte == 8'd0)
		else $error("status result carries data");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'd5)
		else $error("status out of range");
endmodule

bind frame_receive_ack_engine frak_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .out_byte, .status, .last
);
`default_nettype wire
